// File: hw/rtl/lse_pkg.sv
package lse_pkg;

  typedef struct packed {
    logic [7:0] spawn_hue;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
  } lse_in_t;

  typedef struct packed {
    logic [2:0] pixel_index;
    logic [7:0] pixel_hue;
    logic [7:0] pixel_saturation;
    logic [7:0] pixel_value;
    logic       last_pixel;
  } lse_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic update;
    logic emit;
  } lse_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;
    logic last_pix;
  } lse_sts_t;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_HUE    = 2'd1;

  localparam logic [3:0] MODE_STATIC     = 4'd0;
  localparam logic [3:0] MODE_PULSE      = 4'd1;
  localparam logic [3:0] MODE_PONG_BASE  = 4'd2;
  localparam logic [3:0] MODE_PONG_CYCLE = 4'd3;
  localparam logic [3:0] MODE_RAINBOW    = 4'd4;
  localparam logic [3:0] MODE_SHIFT      = 4'd5;
  localparam logic [3:0] MODE_TETRIS     = 4'd6;
  localparam logic [3:0] MODE_DIGIT      = 4'd7;
  localparam logic [3:0] MODE_OFF        = 4'd8;

  localparam logic [1:0] PHASE_GEN   = 2'd0;
  localparam logic [1:0] PHASE_SLIDE = 2'd1;
  localparam logic [1:0] PHASE_SHIFT = 2'd2;

  localparam logic [7:0] FULL_LEVEL       = 8'd255;
  localparam logic [7:0] PONG_DECAY_BASE  = 8'd12;
  localparam logic [7:0] PONG_DECAY_CYCLE = 8'd5;
  localparam logic [7:0] PONG_LIMIT_BASE  = 8'd3;
  localparam logic [7:0] PONG_LIMIT_CYCLE = 8'd8;
  localparam logic [7:0] PONG_HUE_STEP    = 8'd8;
  localparam logic [7:0] TETRIS_DIV       = 8'd8;
  localparam logic [7:0] SHIFT_HUE_STEP   = 8'd16;
  localparam logic [7:0] HOUR_HUE_MUL     = 8'd10;
  localparam logic [7:0] MINSEC_HUE_MUL   = 8'd4;

endpackage

// File: hw/rtl/lse_ctrl.sv
module lse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lse_pkg::lse_sts_t sts_i,
  output lse_pkg::lse_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.load_in = 1'b0;
    cmd_o.update  = 1'b0;
    cmd_o.emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        // a tetris tick inside the divider ends here with no beat
        state_d = sts_i.skip ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_pix) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/lse_datapath.sv
module lse_datapath #(
  parameter int unsigned PIXELS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lse_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  lse_pkg::lse_in_t               in_data_i,
  input  lse_pkg::lse_cmd_t              cmd_i,
  output lse_pkg::lse_sts_t              sts_o,
  output lse_pkg::lse_out_t              out_data_o
);

  localparam int unsigned PW = (PIXELS > 2) ? $clog2(PIXELS) : 1;
  localparam logic [PW-1:0] LAST_K = PW'(PIXELS - 1);
  localparam logic [7:0] POS_TOP  = 8'(PIXELS + 3);
  localparam logic [7:0] POS_LIT  = 8'(PIXELS + 2);

  logic [3:0]  mode_q;
  logic [7:0]  base_q;
  lse_pkg::lse_in_t  in_q;
  lse_pkg::lse_out_t out_q, out_d;

  logic [7:0]    tick_q, tick_d;
  logic          dir_q, dir_d;
  logic [7:0]    hue_q, hue_d;
  logic [7:0]    pos_q, pos_d;
  logic [1:0]    phase_q, phase_d;
  logic [PW-1:0] k_q, k_d;
  logic          relight_q, relight_d;
  logic [1:0]    op_q, op_d;
  logic          moved_q, moved_d;
  logic [7:0]    carry_q, carry_d;
  logic [7:0]    lvl_q [PIXELS];
  logic [7:0]    lvl_d [PIXELS];

  logic [7:0]  tet_tick;
  logic        skip;
  logic        gen_spawn;
  logic        last_k;
  logic [7:0]  head, nxt;
  logic [7:0]  fv;
  logic        zero_next, move_now;
  logic        hit;
  logic [7:0]  pv, decay, wb_pong, wb;
  logic [31:0] idx_w, grp_w;
  logic [7:0]  pulse_t, pong_p;
  logic [7:0]  step_cur, step_flip;

  assign tet_tick  = tick_q + 8'd1;
  assign skip      = (mode_q == lse_pkg::MODE_TETRIS) && (tet_tick <= lse_pkg::TETRIS_DIV);
  assign gen_spawn = cmd_i.update && (mode_q == lse_pkg::MODE_TETRIS) && !skip &&
                     (phase_q != lse_pkg::PHASE_SLIDE) && (phase_q != lse_pkg::PHASE_SHIFT) &&
                     (lvl_q[PIXELS-1] == 8'd0);
  assign step_cur  = dir_q ? 8'hFF : 8'h01;
  assign step_flip = dir_q ? 8'h01 : 8'hFF;

  assign last_k = (k_q == LAST_K);
  assign head   = lvl_q[0];
  assign nxt    = lvl_q[1];
  assign idx_w  = 32'(k_q);
  assign grp_w  = idx_w >> 1;

  assign sts_o.skip     = skip;
  assign sts_o.last_pix = last_k;
  assign out_data_o     = out_q;

  // tetris move for the pixel at the head of the rotation
  always_comb begin
    fv        = head;
    zero_next = 1'b0;
    move_now  = 1'b0;
    if (op_q == lse_pkg::PHASE_SLIDE) begin
      if (head == 8'd0 && !last_k && nxt != 8'd0) begin
        fv        = nxt;
        zero_next = 1'b1;
        move_now  = 1'b1;
      end
    end else if (op_q == lse_pkg::PHASE_SHIFT && !moved_q) begin
      if (k_q == '0 && head != 8'd0) begin
        // drop the block off pixel zero
        fv       = 8'd0;
        move_now = 1'b1;
      end else if (head == 8'd0 && !last_k && nxt != 8'd0) begin
        fv        = nxt;
        zero_next = 1'b1;
        move_now  = 1'b1;
      end
    end
  end

  // pong level: relight, show, then decay
  assign hit     = relight_q && ((8'(k_q) + 8'd2) == pos_q);
  assign pv      = hit ? lse_pkg::FULL_LEVEL : head;
  assign decay   = (mode_q == lse_pkg::MODE_PONG_BASE) ? lse_pkg::PONG_DECAY_BASE
                                                       : lse_pkg::PONG_DECAY_CYCLE;
  assign wb_pong = (pv > decay) ? (pv - decay) : 8'd0;

  always_comb begin
    priority if (mode_q == lse_pkg::MODE_PONG_BASE || mode_q == lse_pkg::MODE_PONG_CYCLE) begin
      wb = wb_pong;
    end else if (mode_q == lse_pkg::MODE_TETRIS) begin
      wb = fv;
    end else begin
      wb = head;
    end
  end

  always_comb begin
    out_d.pixel_index      = idx_w[2:0];
    out_d.last_pixel       = last_k;
    out_d.pixel_hue        = base_q;
    out_d.pixel_saturation = lse_pkg::FULL_LEVEL;
    out_d.pixel_value      = lse_pkg::FULL_LEVEL;
    unique case (mode_q)
      lse_pkg::MODE_PULSE: begin
        out_d.pixel_value = tick_q;
      end
      lse_pkg::MODE_PONG_BASE, lse_pkg::MODE_PONG_CYCLE: begin
        out_d.pixel_hue   = hue_q;
        out_d.pixel_value = pv;
      end
      lse_pkg::MODE_RAINBOW: begin
        out_d.pixel_hue = hue_q;
      end
      lse_pkg::MODE_SHIFT: begin
        out_d.pixel_hue = hue_q + 8'(idx_w * 32'(lse_pkg::SHIFT_HUE_STEP));
      end
      lse_pkg::MODE_TETRIS: begin
        if (fv != 8'd0) begin
          out_d.pixel_hue = fv;
        end else begin
          out_d.pixel_hue   = carry_q;
          out_d.pixel_value = 8'd0;
        end
      end
      lse_pkg::MODE_DIGIT: begin
        if (grp_w == 32'd0) begin
          out_d.pixel_hue = 8'({3'b000, in_q.clock_hour} * lse_pkg::HOUR_HUE_MUL);
        end else if (grp_w == 32'd1) begin
          out_d.pixel_hue = 8'({2'b00, in_q.clock_minute} * lse_pkg::MINSEC_HUE_MUL);
        end else if (grp_w == 32'd2) begin
          out_d.pixel_hue = 8'({2'b00, in_q.clock_second} * lse_pkg::MINSEC_HUE_MUL);
        end else begin
          out_d.pixel_hue        = 8'd0;
          out_d.pixel_saturation = 8'd0;
          out_d.pixel_value      = 8'd0;
        end
      end
      lse_pkg::MODE_OFF: begin
        out_d.pixel_hue        = 8'd0;
        out_d.pixel_saturation = 8'd0;
        out_d.pixel_value      = 8'd0;
      end
      default: begin
        out_d.pixel_hue = base_q;
      end
    endcase
  end

  always_comb begin
    pulse_t = tick_q + step_cur;
    if (pulse_t == 8'd0) begin
      pulse_t = pulse_t + step_flip;
    end
    pong_p = pos_q + step_cur;
  end

  always_comb begin
    tick_d    = tick_q;
    dir_d     = dir_q;
    hue_d     = hue_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    k_d       = k_q;
    relight_d = relight_q;
    op_d      = op_q;
    moved_d   = moved_q;
    carry_d   = carry_q;
    if (cmd_i.update) begin
      k_d       = '0;
      relight_d = 1'b0;
      op_d      = lse_pkg::PHASE_GEN;
      moved_d   = 1'b0;
      carry_d   = 8'd0;
      unique case (mode_q)
        lse_pkg::MODE_PULSE: begin
          tick_d = pulse_t;
          if (tick_q + step_cur == 8'd0) begin
            dir_d = !dir_q;
          end
        end
        lse_pkg::MODE_PONG_BASE, lse_pkg::MODE_PONG_CYCLE: begin
          tick_d = tick_q + 8'd1;
          if (tick_q > ((mode_q == lse_pkg::MODE_PONG_BASE) ? lse_pkg::PONG_LIMIT_BASE
                                                             : lse_pkg::PONG_LIMIT_CYCLE)) begin
            tick_d = 8'd0;
            hue_d  = (mode_q == lse_pkg::MODE_PONG_BASE) ? base_q
                                                         : hue_q + lse_pkg::PONG_HUE_STEP;
            if (pong_p == 8'd0 || pong_p == POS_TOP) begin
              dir_d = !dir_q;
            end
            if (pong_p > POS_TOP) begin
              pos_d     = 8'd2;
              relight_d = 1'b1;
            end else begin
              pos_d     = pong_p;
              relight_d = (pong_p > 8'd1) && (pong_p < POS_LIT);
            end
          end
        end
        lse_pkg::MODE_RAINBOW, lse_pkg::MODE_SHIFT: begin
          hue_d = hue_q + 8'd1;
        end
        lse_pkg::MODE_TETRIS: begin
          if (skip) begin
            tick_d = tet_tick;
          end else begin
            tick_d = 8'd0;
            if (phase_q == lse_pkg::PHASE_SLIDE || phase_q == lse_pkg::PHASE_SHIFT) begin
              op_d = phase_q;
            end else if (lvl_q[PIXELS-1] != 8'd0) begin
              phase_d = lse_pkg::PHASE_SHIFT;
            end else begin
              phase_d = lse_pkg::PHASE_SLIDE;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.emit) begin
      k_d     = k_q + PW'(1);
      moved_d = moved_q || move_now;
      if (fv != 8'd0) begin
        carry_d = fv;
      end
      // no move in the whole pass: back to generate
      if (last_k && (op_q == lse_pkg::PHASE_SLIDE || op_q == lse_pkg::PHASE_SHIFT) &&
          !(moved_q || move_now)) begin
        phase_d = lse_pkg::PHASE_GEN;
      end
    end
  end

  // levels rotate one place per beat, head written back at the tail
  always_comb begin
    lvl_d = lvl_q;
    if (cmd_i.emit) begin
      for (int i = 0; i < int'(PIXELS) - 1; i++) begin
        lvl_d[i] = lvl_q[i+1];
      end
      if (zero_next) begin
        lvl_d[0] = 8'd0;
      end
      lvl_d[PIXELS-1] = wb;
    end else if (gen_spawn) begin
      lvl_d[PIXELS-1] = in_q.spawn_hue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lse_pkg::MODE_STATIC;
      base_q    <= 8'd0;
      tick_q    <= 8'd0;
      dir_q     <= 1'b0;
      hue_q     <= 8'd0;
      pos_q     <= 8'd0;
      phase_q   <= lse_pkg::PHASE_GEN;
      k_q       <= '0;
      relight_q <= 1'b0;
      op_q      <= lse_pkg::PHASE_GEN;
      moved_q   <= 1'b0;
      carry_q   <= 8'd0;
      for (int i = 0; i < int'(PIXELS); i++) begin
        lvl_q[i] <= 8'd0;
      end
    end else begin
      if (cfg_we_i && cfg_index_i == lse_pkg::CFG_EFFECT_MODE) begin
        mode_q <= cfg_data_i[3:0];
      end
      if (cfg_we_i && cfg_index_i == lse_pkg::CFG_BASE_HUE) begin
        base_q <= cfg_data_i;
      end
      tick_q    <= tick_d;
      dir_q     <= dir_d;
      hue_q     <= hue_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      k_q       <= k_d;
      relight_q <= relight_d;
      op_q      <= op_d;
      moved_q   <= moved_d;
      carry_q   <= carry_d;
      lvl_q     <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

endmodule

// File: hw/rtl/led_strip_effect_engine.sv
// LED strip effect engine.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per animation
// tick, carrying the tetris spawn hue and the current clock. A beat is taken
// when valid is high and stall is low; the engine stalls while a tick is in
// work and takes only one tick at a time.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per pixel,
// pixel 0 first, last_pixel set on pixel PIXELS-1. A tetris tick inside its
// divider produces no beat.
// Config channel (cfg_valid_i / cfg_ready_o): ready is always high; index 0
// sets the effect mode, index 1 the base hue. Write only while idle.
// After the accepting edge the controller passes through its update state, then
// emits one pixel per cycle from the output register while the receiver does
// not stall; a silent tetris tick returns to idle from the update state. A
// stalled receiver holds the output register and the pixel loop waits on it.
// Reset clears mode, base hue, counters, direction, tetris phase and all
// pixel levels to zero, and drops any pending output beat.
module led_strip_effect_engine #(
  parameter int unsigned PIXELS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lse_pkg::lse_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lse_pkg::lse_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lse_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  lse_pkg::lse_cmd_t cmd;
  lse_pkg::lse_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lse_datapath #(
    .PIXELS (PIXELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/lse_checker.sv
module lse_checker #(
  parameter int unsigned PIXELS = 6
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input lse_pkg::lse_out_t out_data_o
);

  localparam logic [2:0] LAST_IDX = 3'(PIXELS - 1);

  // busy right after a tick is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_pixel) |-> (out_data_o.pixel_index == LAST_IDX))
    else $error("last pixel flag on wrong index");

  a_dark_when_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pixel_saturation == 8'd0) |-> (out_data_o.pixel_value == 8'd0))
    else $error("unsaturated pixel is lit");

endmodule

bind led_strip_effect_engine lse_checker #(
  .PIXELS (PIXELS)
) u_lse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: test/tb_led_strip_effect_engine.sv
module tb_led_strip_effect_engine;

  localparam int unsigned PIXELS      = 6;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          PRINT_LIMIT = 40;

  // indexes that map to no register
  localparam logic [lse_pkg::CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [lse_pkg::CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  lse_pkg::lse_in_t              in_data   = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lse_pkg::lse_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lse_pkg::CfgIdxW-1:0]   cfg_index = lse_pkg::CFG_EFFECT_MODE;
  logic [7:0]                    cfg_data  = 8'd0;

  // engine state as the strip should see it
  logic [3:0] mode_r    = lse_pkg::MODE_STATIC;
  logic [7:0] hue_r     = 8'd0;
  logic [7:0] tick_r    = 8'd0;
  logic       down_r    = 1'b0;
  logic [7:0] run_hue_r = 8'd0;
  logic [7:0] lit_r     = 8'd0;
  logic [7:0] level_r [PIXELS] = '{default: 8'd0};
  logic [1:0] phase_r   = lse_pkg::PHASE_GEN;

  lse_pkg::lse_out_t pending_pixels [$];

  int err_cnt    = 0;
  int cycle_cnt  = 0;
  int stall_left = 0;
  bit calm_tx    = 1'b0;
  bit calm_rx    = 1'b0;

  led_strip_effect_engine #(
    .PIXELS(PIXELS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (err_cnt < PRINT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic void push_pixel(input int k, input logic [7:0] h, s, v);
    lse_pkg::lse_out_t p;
    p.pixel_index      = 3'(k);
    p.pixel_hue        = h;
    p.pixel_saturation = s;
    p.pixel_value      = v;
    p.last_pixel       = (k == PIXELS - 1);
    pending_pixels.push_back(p);
  endfunction

  function automatic logic [7:0] dir_step();
    return down_r ? 8'hFF : 8'd1;
  endfunction

  // Advance the engine state by one tick and queue the pixels it shows.
  function automatic void render_tick(input lse_pkg::lse_in_t t);
    logic [7:0] old;
    logic [7:0] decay;
    logic [7:0] limit;
    logic [7:0] hue;
    bit         own;
    bit         moved;
    case (mode_r)
      lse_pkg::MODE_PULSE: begin
        tick_r += dir_step();
        if (tick_r == 8'd0) begin
          down_r = ~down_r;
          tick_r += dir_step();
        end
        for (int k = 0; k < PIXELS; k++) push_pixel(k, hue_r, lse_pkg::FULL_LEVEL, tick_r);
      end
      lse_pkg::MODE_PONG_BASE, lse_pkg::MODE_PONG_CYCLE: begin
        own   = (mode_r == lse_pkg::MODE_PONG_BASE);
        decay = own ? lse_pkg::PONG_DECAY_BASE : lse_pkg::PONG_DECAY_CYCLE;
        limit = own ? lse_pkg::PONG_LIMIT_BASE : lse_pkg::PONG_LIMIT_CYCLE;
        old   = tick_r;
        tick_r++;
        if (old > limit) begin
          tick_r = 8'd0;
          lit_r += dir_step();
          run_hue_r = own ? hue_r : run_hue_r + lse_pkg::PONG_HUE_STEP;
          if (lit_r == 0 || lit_r == PIXELS + 3) down_r = ~down_r;
          if (lit_r > PIXELS + 3) lit_r = 8'd2;
          if (lit_r > 1 && lit_r < PIXELS + 2) level_r[lit_r - 2] = lse_pkg::FULL_LEVEL;
        end
        for (int k = 0; k < PIXELS; k++) begin
          push_pixel(k, run_hue_r, lse_pkg::FULL_LEVEL, level_r[k]);
          level_r[k] = (level_r[k] > decay) ? level_r[k] - decay : 8'd0;
        end
      end
      lse_pkg::MODE_RAINBOW: begin
        run_hue_r++;
        for (int k = 0; k < PIXELS; k++) begin
          push_pixel(k, run_hue_r, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
        end
      end
      lse_pkg::MODE_SHIFT: begin
        run_hue_r++;
        for (int k = 0; k < PIXELS; k++) begin
          hue = run_hue_r + lse_pkg::SHIFT_HUE_STEP * k;
          push_pixel(k, hue, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
        end
      end
      lse_pkg::MODE_TETRIS: begin
        tick_r++;
        if (tick_r > lse_pkg::TETRIS_DIV) begin
          tick_r = 8'd0;
          moved  = 1'b0;
          case (phase_r)
            lse_pkg::PHASE_SLIDE: begin
              for (int k = 0; k < PIXELS - 1; k++) begin
                if (level_r[k] == 0 && level_r[k + 1] != 0) begin
                  moved          = 1'b1;
                  level_r[k]     = level_r[k + 1];
                  level_r[k + 1] = 8'd0;
                end
              end
              if (!moved) phase_r = lse_pkg::PHASE_GEN;
            end
            lse_pkg::PHASE_SHIFT: begin
              // only the lowest block moves; pixel 0 falls off the strip
              for (int k = 0; k < PIXELS; k++) begin
                if (!moved && level_r[k] != 0) begin
                  if (k > 0) level_r[k - 1] = level_r[k];
                  level_r[k] = 8'd0;
                  moved      = 1'b1;
                end
              end
              if (!moved) phase_r = lse_pkg::PHASE_GEN;
            end
            default: begin
              if (level_r[PIXELS - 1] != 0) begin
                phase_r = lse_pkg::PHASE_SHIFT;
              end else begin
                level_r[PIXELS - 1] = t.spawn_hue;
                phase_r             = lse_pkg::PHASE_SLIDE;
              end
            end
          endcase
          hue = 8'd0;
          for (int k = 0; k < PIXELS; k++) begin
            if (level_r[k] != 0) begin
              hue = level_r[k];
              push_pixel(k, hue, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
            end else begin
              push_pixel(k, hue, lse_pkg::FULL_LEVEL, 8'd0);
            end
          end
        end
      end
      lse_pkg::MODE_DIGIT: begin
        for (int k = 0; k < PIXELS; k++) begin
          case (k / 2)
            0: begin
              hue = lse_pkg::HOUR_HUE_MUL * t.clock_hour;
              push_pixel(k, hue, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
            end
            1: begin
              hue = lse_pkg::MINSEC_HUE_MUL * t.clock_minute;
              push_pixel(k, hue, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
            end
            2: begin
              hue = lse_pkg::MINSEC_HUE_MUL * t.clock_second;
              push_pixel(k, hue, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
            end
            default: push_pixel(k, 8'd0, 8'd0, 8'd0);
          endcase
        end
      end
      lse_pkg::MODE_OFF: begin
        for (int k = 0; k < PIXELS; k++) push_pixel(k, 8'd0, 8'd0, 8'd0);
      end
      default: begin
        for (int k = 0; k < PIXELS; k++) begin
          push_pixel(k, hue_r, lse_pkg::FULL_LEVEL, lse_pkg::FULL_LEVEL);
        end
      end
    endcase
  endfunction

  function automatic lse_pkg::lse_in_t pack_tick(input logic [7:0] spawn,
                                                 input logic [4:0] hr,
                                                 input logic [5:0] mi,
                                                 input logic [5:0] se);
    lse_pkg::lse_in_t t;
    t.spawn_hue    = spawn;
    t.clock_hour   = hr;
    t.clock_minute = mi;
    t.clock_second = se;
    return t;
  endfunction

  // Mostly legal clock and spawn values, with the odd zero, 255 or out-of-range value.
  function automatic lse_pkg::lse_in_t rand_tick();
    logic [7:0] spawn;
    logic [4:0] hr;
    logic [5:0] mi;
    logic [5:0] se;
    case ($urandom_range(0, 15))
      0:       spawn = 8'd0;
      1:       spawn = 8'd255;
      default: spawn = 8'($urandom_range(1, 254));
    endcase
    hr = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    mi = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    se = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    return pack_tick(spawn, hr, mi, se);
  endfunction

  task automatic send_tick(input lse_pkg::lse_in_t t);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    render_tick(t);
  endtask

  // Hold the sender off until every queued pixel has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // Drain, then let a silent tick finish before touching registers.
  task automatic settle();
    drain();
    repeat (PIXELS + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lse_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lse_pkg::CFG_EFFECT_MODE) begin
      mode_r = val[3:0];
    end else if (idx == lse_pkg::CFG_BASE_HUE) begin
      hue_r = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input logic [3:0] m);
    settle();
    // upper bits are junk the register must drop
    write_reg(lse_pkg::CFG_EFFECT_MODE, {4'($urandom_range(0, 15)), m});
  endtask

  task automatic test_each_effect();
    send_tick(pack_tick(8'd1, 5'd0, 6'd0, 6'd0));
    send_tick(pack_tick(8'd254, 5'd23, 6'd59, 6'd59));
    settle();
    write_reg(lse_pkg::CFG_BASE_HUE, 8'hFF);
    write_reg(CFG_SPARE_B, 8'hFF);
    write_reg(CFG_SPARE_A, 8'h00);
    set_mode(lse_pkg::MODE_STATIC);
    send_tick(rand_tick());
    set_mode(lse_pkg::MODE_PULSE);
    repeat (2) send_tick(rand_tick());
    set_mode(lse_pkg::MODE_PONG_BASE);
    repeat (4) send_tick(rand_tick());
    set_mode(lse_pkg::MODE_PONG_CYCLE);
    repeat (2) send_tick(rand_tick());
    set_mode(lse_pkg::MODE_RAINBOW);
    send_tick(rand_tick());
    set_mode(lse_pkg::MODE_SHIFT);
    send_tick(rand_tick());
    set_mode(lse_pkg::MODE_DIGIT);
    send_tick(pack_tick(8'd7, 5'd23, 6'd59, 6'd59));
    send_tick(pack_tick(8'd7, 5'd0, 6'd0, 6'd0));
    send_tick(pack_tick(8'd7, 5'd31, 6'd63, 6'd63));
    set_mode(lse_pkg::MODE_OFF);
    send_tick(rand_tick());
    // unused mode code falls back to static
    settle();
    write_reg(lse_pkg::CFG_EFFECT_MODE, 8'hFF);
    send_tick(rand_tick());
    set_mode(lse_pkg::MODE_TETRIS);
    repeat (9) send_tick(pack_tick(8'hFF, 5'd12, 6'd30, 6'd30));
  endtask

  // Step the brightness over a run of ticks with changing pacing.
  task automatic test_pulse_sweep();
    set_mode(lse_pkg::MODE_PULSE);
    for (int i = 0; i < 24; i++) begin
      if (i % 8 == 0) begin
        calm_tx = ($urandom_range(0, 2) == 0);
        calm_rx = ($urandom_range(0, 2) == 0);
      end
      send_tick(rand_tick());
    end
  endtask

  task automatic test_pong();
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    settle();
    write_reg(lse_pkg::CFG_BASE_HUE, 8'h00);
    set_mode(lse_pkg::MODE_PONG_BASE);
    repeat (10) send_tick(rand_tick());
    settle();
    write_reg(lse_pkg::CFG_BASE_HUE, 8'($urandom_range(0, 255)));
    repeat (10) send_tick(rand_tick());
    set_mode(lse_pkg::MODE_PONG_CYCLE);
    repeat (20) send_tick(rand_tick());
  endtask

  // Long enough to land a few blocks and watch them slide down.
  task automatic test_tetris();
    set_mode(lse_pkg::MODE_TETRIS);
    for (int i = 0; i < 150; i++) begin
      if (i % 30 == 0) begin
        calm_tx = ($urandom_range(0, 3) == 0);
        calm_rx = ($urandom_range(0, 3) == 0);
      end
      send_tick(rand_tick());
    end
  endtask

  task automatic test_mixed_modes();
    int n;
    for (int ph = 0; ph < 4; ph++) begin
      n       = $urandom_range(6, 16);
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      set_mode(4'($urandom_range(0, 15)));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(lse_pkg::CFG_BASE_HUE, 8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 24) == 0) drain();
        send_tick(rand_tick());
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lse_pkg::lse_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel %0d beat with nothing expected", out_data.pixel_index));
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_index", out_data.pixel_index, want.pixel_index);
        check_field("pixel_hue", out_data.pixel_hue, want.pixel_hue);
        check_field("pixel_saturation", out_data.pixel_saturation, want.pixel_saturation);
        check_field("pixel_value", out_data.pixel_value, want.pixel_value);
        check_field("last_pixel", out_data.last_pixel, want.last_pixel);
      end
      stall_left <= calm_rx ? 0 : $urandom_range(0, 9);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_led_strip_effect_engine: errors");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_each_effect();
    test_pulse_sweep();
    test_pong();
    test_tetris();
    test_mixed_modes();
    settle();
    if (err_cnt == 0) begin
      $display("tb_led_strip_effect_engine: clean");
    end else begin
      $display("tb_led_strip_effect_engine: errors");
    end
    $finish;
  end

endmodule
